// ===== rtl/playfair_digram_cipher_defines.svh =====
// ----------------------------------------------------------------------------
// Playfair digram cipher - assertion macros
// Clocked checks on clk, disabled while rst_n is low; empty when ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAM_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAM_CIPHER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define PFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset
`define PFC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PFC_ASSERT(lbl, prop, msg)
`define PFC_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Playfair digram cipher - shared package
// Letter constants, opcodes, rule codes, table port structs and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int unsigned ALPHABET = 26;
  localparam int unsigned CELLS    = 25;
  localparam int unsigned SIDE     = 5;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_DONE = 2'd1,
    OP_TEXT = 2'd2,
    OP_END  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RULE_ROW  = 2'd0,
    RULE_COL  = 2'd1,
    RULE_RECT = 2'd2
  } rule_t;

  // Write port: square cell gets the letter, the letter gets its position
  typedef struct packed {
    logic       we;
    logic [4:0] slot;
    logic [4:0] letter;
    logic [5:0] pos;
  } tbl_wr_t;

  // Read requests for both memories
  typedef struct packed {
    logic       pos_re;
    logic [4:0] pos_a;
    logic [4:0] pos_b;
    logic       sq_re;
    logic [4:0] sq_a;
    logic [4:0] sq_b;
  } tbl_rd_t;

  // Registered read data
  typedef struct packed {
    logic [5:0] pos_a;
    logic [5:0] pos_b;
    logic [4:0] sq_a;
    logic [4:0] sq_b;
  } tbl_q_t;

  // Result handed to the output register
  typedef struct packed {
    logic       valid;
    logic [4:0] first;
    logic [4:0] second;
    rule_t      rule;
  } res_t;

  // j is looked up as i inside a pair
  function automatic logic [4:0] map_j(input logic [4:0] l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  // Fold a 3-bit coordinate into 0..4
  function automatic logic [2:0] mod5(input logic [2:0] v);
    return (v >= 3'(SIDE)) ? v - 3'(SIDE) : v;
  endfunction

  // Step a coordinate with wrap-around
  function automatic logic [2:0] inc5(input logic [2:0] v);
    return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  // Row-major cell index r*5 + c
  function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + 5'(r) + 5'(c);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfc_tables.sv =====
// ----------------------------------------------------------------------------
// Playfair digram cipher - square and position memories
// Two synchronous memories, one write and two registered reads each.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_tables
  import pfc_pkg::*;
(
  input  wire logic    clk,
  input  wire tbl_wr_t wr,
  input  wire tbl_rd_t rd,
  output tbl_q_t       q
);

  logic [4:0] sq_mem  [0:CELLS-1];
  logic [5:0] pos_mem [0:ALPHABET-1];

  logic [5:0] pos_a_r, pos_b_r;
  logic [4:0] sq_a_r, sq_b_r;

  // Write the cell and the letter's position together
  always_ff @(posedge clk) begin
    if (wr.we) begin
      sq_mem[wr.slot]    <= wr.letter;
      pos_mem[wr.letter] <= wr.pos;
    end
  end

  // Read positions; hold data until the next request
  always_ff @(posedge clk) begin
    if (rd.pos_re) begin
      pos_a_r <= pos_mem[rd.pos_a];
      pos_b_r <= pos_mem[rd.pos_b];
    end
  end

  // Read cipher cells; hold data until the next request
  always_ff @(posedge clk) begin
    if (rd.sq_re) begin
      sq_a_r <= sq_mem[rd.sq_a];
      sq_b_r <= sq_mem[rd.sq_b];
    end
  end

  assign q.pos_a = pos_a_r;
  assign q.pos_b = pos_b_r;
  assign q.sq_a  = sq_a_r;
  assign q.sq_b  = sq_b_r;

endmodule

`default_nettype wire

// ===== rtl/pfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Playfair digram cipher - sequencer
// Key placement, key-done fill sweep, pairing and the two-read encipher walk.
// ----------------------------------------------------------------------------
`default_nettype none

`include "playfair_digram_cipher_defines.svh"

module pfc_ctrl
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_opcode,
  input  wire logic [4:0] in_letter,
  input  wire logic [4:0] filler,
  input  wire logic       out_free,
  output res_t            res,
  output tbl_wr_t         wr,
  output tbl_rd_t         rd,
  input  wire tbl_q_t     q
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_POS  = 4'b0100,
    ST_SQ   = 4'b1000
  } state_t;

  localparam logic [ALPHABET-1:0] USED_RESET = ALPHABET'(1) << LETTER_J;

  state_t              state_r, state_nxt;
  logic [ALPHABET-1:0] used_r, used_nxt;
  logic [4:0]          fill_r, fill_nxt;
  logic [2:0]          row_r, row_nxt;
  logic [2:0]          col_r, col_nxt;
  logic [4:0]          k_r, k_nxt;
  logic                square_ready_r, square_ready_nxt;
  logic [4:0]          held_r, held_nxt;
  logic                held_valid_r, held_valid_nxt;
  rule_t               rule_r, rule_nxt;

  logic                accept;
  logic                letter_ok;
  logic                fill_last;
  logic                new_key;
  logic                place_en;
  logic [4:0]          place_letter;
  logic [4:0]          fill_base;
  logic [2:0]          row_base, col_base;
  logic [ALPHABET-1:0] used_base;
  logic                enc;
  logic [4:0]          enc_b;
  logic [2:0]          ra, ca, rb, cb;

  assign accept    = in_valid && in_ready;
  assign letter_ok = in_letter < 5'(ALPHABET);
  assign fill_last = (state_r == ST_FILL) && (k_r == 5'(ALPHABET - 1));
  assign new_key   = accept && (in_opcode == OP_KEY) && square_ready_r;

  // Coordinates of the pair just read from the position memory
  assign ra = mod5(q.pos_a[5:3]);
  assign ca = mod5(q.pos_a[2:0]);
  assign rb = mod5(q.pos_b[5:3]);
  assign cb = mod5(q.pos_b[2:0]);

  // Next-state logic
  always_comb begin
    state_nxt        = state_r;
    used_nxt         = used_r;
    fill_nxt         = fill_r;
    row_nxt          = row_r;
    col_nxt          = col_r;
    k_nxt            = k_r;
    square_ready_nxt = square_ready_r;
    held_nxt         = held_r;
    held_valid_nxt   = held_valid_r;
    rule_nxt         = rule_r;
    in_ready         = (state_r == ST_IDLE);
    wr               = '0;
    rd               = '0;
    place_en         = 1'b0;
    place_letter     = in_letter;
    fill_base        = fill_r;
    row_base         = row_r;
    col_base         = col_r;
    used_base        = used_r;
    enc              = 1'b0;
    enc_b            = filler;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(in_opcode))
            OP_KEY: begin
              // A key letter after key-done opens a new square
              if (new_key) begin
                used_base        = USED_RESET;
                fill_base        = '0;
                row_base         = '0;
                col_base         = '0;
                square_ready_nxt = 1'b0;
                held_valid_nxt   = 1'b0;
                held_nxt         = '0;
              end
              used_nxt  = used_base;
              fill_nxt  = fill_base;
              row_nxt   = row_base;
              col_nxt   = col_base;
              place_en  = letter_ok && !used_base[in_letter] && (fill_base < 5'(CELLS));
            end
            OP_DONE: begin
              k_nxt     = '0;
              state_nxt = ST_FILL;
            end
            OP_TEXT: begin
              if (letter_ok) begin
                if (!held_valid_r) begin
                  held_nxt       = in_letter;
                  held_valid_nxt = 1'b1;
                end else if (held_r == in_letter) begin
                  // Doubled pair: split with the filler, keep the letter held
                  enc   = 1'b1;
                  enc_b = filler;
                end else begin
                  enc            = 1'b1;
                  enc_b          = in_letter;
                  held_valid_nxt = 1'b0;
                  held_nxt       = '0;
                end
              end
            end
            OP_END: begin
              // Pad an odd leftover letter
              if (held_valid_r) begin
                enc            = 1'b1;
                enc_b          = filler;
                held_valid_nxt = 1'b0;
                held_nxt       = '0;
              end
            end
            default: ;
          endcase
          if (enc) begin
            rd.pos_re = 1'b1;
            rd.pos_a  = map_j(held_r);
            rd.pos_b  = map_j(enc_b);
            state_nxt = ST_POS;
          end
        end
      end

      ST_FILL: begin
        // Sweep the alphabet, placing each unused letter
        place_letter = k_r;
        place_en     = !used_r[k_r] && (fill_r < 5'(CELLS));
        if (fill_last) begin
          square_ready_nxt = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          k_nxt = k_r + 5'd1;
        end
      end

      ST_POS: begin
        // Pick the rule and request both cipher cells
        rd.sq_re = 1'b1;
        if (ra == rb) begin
          rule_nxt = RULE_ROW;
          rd.sq_a  = cell_idx(ra, inc5(ca));
          rd.sq_b  = cell_idx(rb, inc5(cb));
        end else if (ca == cb) begin
          rule_nxt = RULE_COL;
          rd.sq_a  = cell_idx(inc5(ra), ca);
          rd.sq_b  = cell_idx(inc5(rb), cb);
        end else begin
          rule_nxt = RULE_RECT;
          rd.sq_a  = cell_idx(ra, cb);
          rd.sq_b  = cell_idx(rb, ca);
        end
        state_nxt = ST_SQ;
      end

      ST_SQ: begin
        // Hold until the output register is free
        if (out_free) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Place one letter at the current fill position
    if (place_en) begin
      wr.we                  = 1'b1;
      wr.slot                = fill_base;
      wr.letter              = place_letter;
      wr.pos                 = {row_base, col_base};
      used_nxt[place_letter] = 1'b1;
      fill_nxt               = fill_base + 5'd1;
      if (col_base == 3'(SIDE - 1)) begin
        col_nxt = '0;
        row_nxt = row_base + 3'd1;
      end else begin
        col_nxt = col_base + 3'd1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      used_r         <= USED_RESET;
      fill_r         <= '0;
      row_r          <= '0;
      col_r          <= '0;
      k_r            <= '0;
      square_ready_r <= 1'b0;
      held_r         <= '0;
      held_valid_r   <= 1'b0;
      rule_r         <= RULE_ROW;
    end else begin
      state_r        <= state_nxt;
      used_r         <= used_nxt;
      fill_r         <= fill_nxt;
      row_r          <= row_nxt;
      col_r          <= col_nxt;
      k_r            <= k_nxt;
      square_ready_r <= square_ready_nxt;
      held_r         <= held_nxt;
      held_valid_r   <= held_valid_nxt;
      rule_r         <= rule_nxt;
    end
  end

  assign res.valid  = (state_r == ST_SQ);
  assign res.first  = q.sq_a;
  assign res.second = q.sq_b;
  assign res.rule   = rule_r;

  `PFC_ASSERT(a_fill_sets_ready, fill_last |=> square_ready_r, "fill sweep left square not ready")
  `PFC_ASSERT_NEVER(a_fill_bound, fill_r > 5'(CELLS), "fill count ran past the square")
  `PFC_ASSERT_NEVER(a_j_never_free, !used_r[LETTER_J], "j marked as free for placement")
  `PFC_ASSERT(a_new_key_drops_held, new_key |=> !held_valid_r, "new key kept a held letter")
  `PFC_ASSERT(a_result_waits, (res.valid && !out_free) |=> res.valid, "pair dropped while output busy")

endmodule

`default_nettype wire

// ===== rtl/playfair_digram_cipher.sv =====
// ----------------------------------------------------------------------------
// Playfair digram cipher - top level
// Builds a 5x5 key square in memory and enciphers plaintext letter pairs.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  in      | input     | in_valid/ready   | in_opcode, in_letter
//  out     | output    | out_valid/ready  | out_first_cipher, out_second_cipher, out_rule_used
//  cfg     | input     | cfg_valid/ready  | cfg_filler_letter
//
//  Key letter, a plaintext letter that is only held, and text done with nothing held: handled in idle.
//  A pair to encipher: position read, then cell read, then result (held while the output is busy).
//  Key done: a fill sweep through the alphabet, one alphabet letter per cycle.
//  Synchronous active-low reset; the memories need no clearing pass.
//  A stalled output holds one finished pair; a second pair waits in the sequencer
//  and stops the input until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digram_cipher
  import pfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_opcode,
  input  wire logic [4:0] in_letter,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_first_cipher,
  output logic [4:0]      out_second_cipher,
  output logic [1:0]      out_rule_used,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [4:0] cfg_filler_letter
);

  logic [4:0] filler_r;
  logic [4:0] filler_eff;
  logic       out_valid_r;
  logic [4:0] first_r, second_r;
  logic [1:0] rule_r;
  logic       out_free;
  res_t       res;
  tbl_wr_t    wr;
  tbl_rd_t    rd;
  tbl_q_t     q;

  assign cfg_ready  = 1'b1;
  assign filler_eff = (filler_r < 5'(ALPHABET)) ? filler_r : LETTER_X;
  assign out_free   = !out_valid_r || out_ready;

  // Filler register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filler_r <= LETTER_X;
    end else if (cfg_valid && cfg_ready) begin
      filler_r <= cfg_filler_letter;
    end
  end

  // Output register: load a finished pair, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      first_r  <= res.first;
      second_r <= res.second;
      rule_r   <= res.rule;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_cipher  = first_r;
  assign out_second_cipher = second_r;
  assign out_rule_used     = rule_r;

  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_letter (in_letter),
    .filler    (filler_eff),
    .out_free  (out_free),
    .res       (res),
    .wr        (wr),
    .rd        (rd),
    .q         (q)
  );

  pfc_tables u_tables (
    .clk (clk),
    .wr  (wr),
    .rd  (rd),
    .q   (q)
  );

endmodule

`default_nettype wire
